[rtl/cdo_pkg.sv]
// Shared types, constants and calendar functions for the date offset block.
package cdo_pkg;

  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned YearW   = 16;
  localparam int unsigned OffsetW = 17;
  localparam int unsigned Mod100W = 7;
  localparam int unsigned CentW   = 2;
  localparam int unsigned QuoW    = 10;
  localparam int unsigned RecipW  = 17;
  localparam int unsigned RecipSh = 23;

  typedef logic [MonthW-1:0]  month_t;
  typedef logic [DayW-1:0]    day_t;
  typedef logic [YearW-1:0]   year_t;
  typedef logic [OffsetW-1:0] offset_t;
  typedef logic [Mod100W-1:0] mod100_t;
  typedef logic [CentW-1:0]   cent_t;
  typedef logic [QuoW-1:0]    quo_t;

  localparam month_t MonthJan = 4'd1;
  localparam month_t MonthFeb = 4'd2;
  localparam month_t MonthApr = 4'd4;
  localparam month_t MonthJun = 4'd6;
  localparam month_t MonthSep = 4'd9;
  localparam month_t MonthNov = 4'd11;
  localparam month_t MonthDec = 4'd12;

  localparam day_t DayFirst    = 5'd1;
  localparam day_t DaysFeb     = 5'd28;
  localparam day_t DaysFebLeap = 5'd29;
  localparam day_t Days30      = 5'd30;
  localparam day_t Days31      = 5'd31;

  localparam year_t   YearMax     = 16'hFFFF;
  localparam mod100_t Mod100      = 7'd100;
  localparam mod100_t Mod100Last  = 7'd99;
  localparam mod100_t YearMaxRem  = 7'd35;
  localparam cent_t   YearMaxCent = 2'd3;

  // Rounded-up reciprocal of 100 scaled by 2^23; exact quotient for every 16-bit year.
  localparam logic [RecipW-1:0] Mod100Recip = 17'd83887;

  // Date position: month, day, the year with its remainder modulo 100 and the century count modulo 4.
  typedef struct packed {
    month_t  month;
    day_t    day;
    year_t   year;
    mod100_t yr_mod100;
    cent_t   cent_mod4;
  } cdo_pos_t;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StDiv   = 5'b00010,
    StRem   = 5'b00100,
    StClamp = 5'b01000,
    StRun   = 5'b10000
  } cdo_state_e;

  function automatic logic is_leap(input cdo_pos_t p);
    logic leap;
    if (p.yr_mod100 == '0) begin
      leap = (p.cent_mod4 == '0);
    end else begin
      leap = (p.year[1:0] == 2'b00);
    end
    return leap;
  endfunction

  function automatic day_t month_len(input month_t m, input logic leap);
    day_t len;
    if (m == MonthFeb) begin
      len = leap ? DaysFebLeap : DaysFeb;
    end else if (m == MonthApr || m == MonthJun || m == MonthSep || m == MonthNov) begin
      len = Days30;
    end else begin
      len = Days31;
    end
    return len;
  endfunction

endpackage

[rtl/cdo_req_if.sv]
// Request channel carrying a start date and a signed day offset.
interface cdo_req_if;
  import cdo_pkg::*;

  logic                  valid;
  logic                  ready;
  month_t                start_month;
  day_t                  start_day;
  year_t                 start_year;
  logic signed [OffsetW-1:0] day_offset;

  modport source (output valid, start_month, start_day, start_year, day_offset, input ready);
  modport sink (input valid, start_month, start_day, start_year, day_offset, output ready);
endinterface

[rtl/cdo_rsp_if.sv]
// Response channel carrying the shifted date and the clamp flags.
interface cdo_rsp_if;
  import cdo_pkg::*;

  logic   valid;
  logic   ready;
  month_t result_month;
  day_t   result_day;
  year_t  result_year;
  logic   month_clamped;
  logic   day_clamped;

  modport source (output valid, result_month, result_day, result_year, month_clamped,
                  day_clamped, input ready);
  modport sink (input valid, result_month, result_day, result_year, month_clamped,
                day_clamped, output ready);
endinterface

[rtl/cdo_step.sv]
// Month step unit: moves a date by whole months or finishes inside the current month.
module cdo_step (
  input  cdo_pkg::cdo_pos_t pos_i,
  input  cdo_pkg::offset_t  rem_i,
  input  logic              back_i,
  output cdo_pkg::cdo_pos_t pos_o,
  output cdo_pkg::offset_t  rem_o,
  output logic              last_o
);
  import cdo_pkg::*;

  logic     leap;
  day_t     len_cur;
  day_t     len_prev;
  day_t     room;
  month_t   prev_month;
  cdo_pos_t year_up;
  cdo_pos_t year_dn;

  assign leap       = is_leap(pos_i);
  assign len_cur    = month_len(pos_i.month, leap);
  assign room       = len_cur - pos_i.day;
  assign prev_month = (pos_i.month == MonthJan) ? MonthDec : pos_i.month - MonthJan;
  assign len_prev   = month_len(prev_month, leap);

  always_comb begin
    year_up = pos_i;
    if (pos_i.year == YearMax) begin
      year_up.year      = '0;
      year_up.yr_mod100 = '0;
      year_up.cent_mod4 = '0;
    end else begin
      year_up.year = pos_i.year + 1'b1;
      if (pos_i.yr_mod100 == Mod100Last) begin
        year_up.yr_mod100 = '0;
        year_up.cent_mod4 = pos_i.cent_mod4 + 1'b1;
      end else begin
        year_up.yr_mod100 = pos_i.yr_mod100 + 1'b1;
      end
    end
  end

  always_comb begin
    year_dn = pos_i;
    if (pos_i.year == '0) begin
      year_dn.year      = YearMax;
      year_dn.yr_mod100 = YearMaxRem;
      year_dn.cent_mod4 = YearMaxCent;
    end else begin
      year_dn.year = pos_i.year - 1'b1;
      if (pos_i.yr_mod100 == '0) begin
        year_dn.yr_mod100 = Mod100Last;
        year_dn.cent_mod4 = pos_i.cent_mod4 - 1'b1;
      end else begin
        year_dn.yr_mod100 = pos_i.yr_mod100 - 1'b1;
      end
    end
  end

  always_comb begin
    pos_o  = pos_i;
    rem_o  = rem_i;
    last_o = 1'b0;
    if (!back_i) begin
      if (rem_i <= OffsetW'(room)) begin
        last_o    = 1'b1;
        pos_o.day = pos_i.day + rem_i[DayW-1:0];
        rem_o     = '0;
      end else begin
        rem_o = rem_i - OffsetW'(room) - OffsetW'(1);
        if (pos_i.month == MonthDec) begin
          pos_o       = year_up;
          pos_o.month = MonthJan;
        end else begin
          pos_o.month = pos_i.month + MonthJan;
        end
        pos_o.day = DayFirst;
      end
    end else begin
      if (rem_i < OffsetW'(pos_i.day)) begin
        last_o    = 1'b1;
        pos_o.day = pos_i.day - rem_i[DayW-1:0];
        rem_o     = '0;
      end else begin
        rem_o = rem_i - OffsetW'(pos_i.day);
        if (pos_i.month == MonthJan) begin
          pos_o = year_dn;
        end
        pos_o.month = prev_month;
        pos_o.day   = len_prev;
      end
    end
  end

endmodule

[rtl/calendar_date_offset.sv]
// Top level: shifts a Gregorian date by a signed day offset, one month per cycle.
//
//   Channel   Dir   Handshake      Carries
//   req_i     in    valid/ready    start month, day, year and signed day offset
//   rsp_o     out   valid/ready    shifted month, day, year and clamp flags
//
// A request passes through the divide state, which divides the year by 100 with a reciprocal
// multiply, the remainder state, which forms the remainder, and the clamp state, which clamps
// the date; the run state then steps through each month crossed, plus a final step inside the
// last month, all through the shared month step unit, until a valid response is formed.
// Reset clears the sequencer and the response valid flag; no clearing pass is needed.
// The request side is ready only when idle. A finished response waits in the output
// register, and a new request is taken while it waits.
module calendar_date_offset (
  input  logic       clk_i,
  input  logic       rst_ni,
  cdo_req_if.sink    req_i,
  cdo_rsp_if.source  rsp_o
);
  import cdo_pkg::*;

  cdo_state_e        state_q, state_d;
  cdo_pos_t          pos_q, pos_d;
  offset_t           rem_q, rem_d;
  logic              back_q, back_d;
  logic              mc_q, mc_d;
  logic              dc_q, dc_d;
  quo_t              quo_q, quo_d;
  logic              out_valid_q, out_valid_d;
  month_t            out_month_q, out_month_d;
  day_t              out_day_q, out_day_d;
  year_t             out_year_q, out_year_d;
  logic              out_mc_q, out_mc_d;
  logic              out_dc_q, out_dc_d;

  cdo_pos_t          step_pos;
  offset_t           step_rem;
  logic              step_last;
  logic [YearW+RecipW-1:0] div_prod;
  year_t             div_rem;
  month_t            cl_month;
  day_t              cl_len;
  logic              req_fire;
  logic              out_free;

  cdo_step u_step (
    .pos_i  (pos_q),
    .rem_i  (rem_q),
    .back_i (back_q),
    .pos_o  (step_pos),
    .rem_o  (step_rem),
    .last_o (step_last)
  );

  assign req_i.ready = (state_q == StIdle);
  assign req_fire    = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;

  assign div_prod = (YearW + RecipW)'(pos_q.year) * (YearW + RecipW)'(Mod100Recip);
  assign div_rem  = pos_q.year - year_t'(quo_q) * year_t'(Mod100);

  always_comb begin
    if (pos_q.month == '0) begin
      cl_month = MonthJan;
    end else if (pos_q.month > MonthDec) begin
      cl_month = MonthDec;
    end else begin
      cl_month = pos_q.month;
    end
  end
  assign cl_len = month_len(cl_month, is_leap(pos_q));

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    rem_d       = rem_q;
    back_d      = back_q;
    mc_d        = mc_q;
    dc_d        = dc_q;
    quo_d       = quo_q;
    out_valid_d = out_valid_q;
    out_month_d = out_month_q;
    out_day_d   = out_day_q;
    out_year_d  = out_year_q;
    out_mc_d    = out_mc_q;
    out_dc_d    = out_dc_q;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (req_fire) begin
          pos_d.month     = req_i.start_month;
          pos_d.day       = req_i.start_day;
          pos_d.year      = req_i.start_year;
          pos_d.yr_mod100 = '0;
          pos_d.cent_mod4 = '0;
          back_d          = req_i.day_offset[OffsetW-1];
          rem_d           = req_i.day_offset[OffsetW-1] ? offset_t'(-req_i.day_offset)
                                                        : offset_t'(req_i.day_offset);
          state_d         = StDiv;
        end
      end
      StDiv: begin
        quo_d           = div_prod[RecipSh +: QuoW];
        pos_d.cent_mod4 = div_prod[RecipSh +: CentW];
        state_d         = StRem;
      end
      StRem: begin
        pos_d.yr_mod100 = div_rem[Mod100W-1:0];
        state_d         = StClamp;
      end
      StClamp: begin
        pos_d.month = cl_month;
        mc_d        = (cl_month != pos_q.month);
        if (pos_q.day == '0) begin
          pos_d.day = DayFirst;
          dc_d      = 1'b1;
        end else if (pos_q.day > cl_len) begin
          pos_d.day = cl_len;
          dc_d      = 1'b1;
        end else begin
          dc_d = 1'b0;
        end
        state_d = StRun;
      end
      StRun: begin
        if (!step_last) begin
          pos_d = step_pos;
          rem_d = step_rem;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_month_d = step_pos.month;
          out_day_d   = step_pos.day;
          out_year_d  = step_pos.year;
          out_mc_d    = mc_q;
          out_dc_d    = dc_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q       <= pos_d;
    rem_q       <= rem_d;
    back_q      <= back_d;
    mc_q        <= mc_d;
    dc_q        <= dc_d;
    quo_q       <= quo_d;
    out_month_q <= out_month_d;
    out_day_q   <= out_day_d;
    out_year_q  <= out_year_d;
    out_mc_q    <= out_mc_d;
    out_dc_q    <= out_dc_d;
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.result_month  = out_month_q;
  assign rsp_o.result_day    = out_day_q;
  assign rsp_o.result_year   = out_year_q;
  assign rsp_o.month_clamped = out_mc_q;
  assign rsp_o.day_clamped   = out_dc_q;

  // The running date is always a real calendar date.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRun |-> pos_q.month >= MonthJan && pos_q.month <= MonthDec &&
                         pos_q.day >= DayFirst &&
                         pos_q.day <= month_len(pos_q.month, is_leap(pos_q)))
    else $error("running date is not a valid calendar date");

  // In the clamp and run states the year remainder modulo 100 stays in its range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRun || state_q == StClamp |-> pos_q.yr_mod100 < Mod100)
    else $error("year remainder out of range");

  // An accepted request always starts the year division.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> state_q == StDiv)
    else $error("accepted request did not start the division");

  // A response is only produced when the step unit reports the final step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRun && state_d == StIdle |-> step_last && out_free)
    else $error("response produced before the offset was consumed");

endmodule
